FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property checked at every rising edge outside of reset.
`define TPS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// An implication checked at every rising edge outside of reset.
`define TPS_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication failed");

`else

`define TPS_ASSERT(name, clk, rst_n, prop, msg)
`define TPS_ASSERT_IMP(name, clk, rst_n, pre, post)

`endif

`endif

FILE: rtl/core/tps_pkg.sv
// ---------------------------------------------------------------------------
// tps_pkg
// Types and constants shared by the brake supervisor modules.
// ---------------------------------------------------------------------------
package tps_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int TIMEOUT_W   = 16;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int DIV_CNT_W   = $clog2(SAMPLE_W + 1);

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd12500;
	localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET = 10'd512;

	// Event codes carried on cmd.
	localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic scan_clear;
		logic scan_step;
		logic div_load;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/core/tps_ram.sv
// ---------------------------------------------------------------------------
// tps_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module tps_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/tps_ctrl.sv
// ---------------------------------------------------------------------------
// tps_ctrl
// Sequencer: accepts an item, runs the window scan and the divider for
// samples, then hands the result to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tps_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tps_pkg::CMD_W-1:0] cmd,
	output logic                      in_stall,
	input  tps_pkg::dp_sts_t          sts,
	output tps_pkg::dp_cmd_t          ctl
);

	tps_pkg::state_t state_q;
	tps_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			tps_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (cmd == tps_pkg::CMD_SAMPLE) begin
						ctl.scan_clear = 1'b1;
						state_d        = tps_pkg::ST_SCAN;
					end else begin
						state_d = tps_pkg::ST_DONE;
					end
				end
			end
			tps_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					ctl.div_load = 1'b1;
					state_d      = tps_pkg::ST_DIV;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			tps_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = tps_pkg::ST_DONE;
				end else begin
					ctl.div_step = 1'b1;
				end
			end
			tps_pkg::ST_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = tps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tps_pkg::ST_IDLE;
			end
		endcase
	end

	`TPS_ASSERT_IMP(a_load_needs_free, clk, arst_n, ctl.out_load, sts.out_free)
	`TPS_ASSERT_IMP(a_sample_scans, clk, arst_n, ctl.accept && (cmd == tps_pkg::CMD_SAMPLE) ##1 1'b1, state_q == tps_pkg::ST_SCAN)
	`TPS_ASSERT_IMP(a_div_then_done, clk, arst_n, (state_q == tps_pkg::ST_DIV) && sts.div_done ##1 1'b1, state_q == tps_pkg::ST_DONE)

endmodule

FILE: rtl/core/tps_datapath.sv
// ---------------------------------------------------------------------------
// tps_datapath
// Flags, tick counter, sample ring, window scan, divider and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tps_datapath #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tps_pkg::CMD_W-1:0]      cmd,
	input  logic [tps_pkg::SAMPLE_W-1:0]   sample,
	input  tps_pkg::dp_cmd_t               ctl,
	output tps_pkg::dp_sts_t               sts,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic                           brake_out,
	output logic                           signal_lost,
	output logic                           overload,
	output logic                           stats_valid,
	output logic [tps_pkg::SAMPLE_W-1:0]   last_sample,
	output logic [tps_pkg::SAMPLE_W-1:0]   average,
	output logic [tps_pkg::SAMPLE_W-1:0]   maximum
);

	localparam int SW    = tps_pkg::SAMPLE_W;
	localparam int TW    = tps_pkg::TIMEOUT_W;
	localparam int PW    = $clog2(WINDOW_DEPTH);
	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = SW + CW;
	localparam int DCW   = tps_pkg::DIV_CNT_W;

	logic [TW-1:0]    timeout_q;
	logic [SW-1:0]    threshold_q;
	logic [TW-1:0]    tick_q;
	logic             loss_q;
	logic             overload_q;
	logic [PW-1:0]    wpos_q;
	logic [CW-1:0]    fill_q;
	logic [SW-1:0]    last_q;
	logic [CW-1:0]    rd_idx_q;
	logic             rd_pend_q;
	logic [SUM_W-1:0] acc_sum_q;
	logic [SW-1:0]    acc_max_q;
	logic [CW-1:0]    rem_q;
	logic [SW-1:0]    quo_q;
	logic [DCW-1:0]   div_cnt_q;
	logic             out_valid_q;
	logic             out_loss_q;
	logic             out_ovl_q;
	logic             out_stats_q;
	logic [SW-1:0]    out_last_q;
	logic [SW-1:0]    out_avg_q;
	logic [SW-1:0]    out_max_q;

	logic [TW:0]      tick_next;
	logic             is_sample;
	logic             rd_en;
	logic [SW-1:0]    rd_data;
	logic [CW:0]      trial;
	logic             trial_ge;

	assign tick_next = {1'b0, tick_q} + {{TW{1'b0}}, 1'b1};
	assign is_sample = ctl.accept && (cmd == tps_pkg::CMD_SAMPLE);
	assign rd_en     = ctl.scan_step && (rd_idx_q != fill_q);
	assign trial     = {rem_q, quo_q[SW-1]};
	assign trial_ge  = trial >= {1'b0, fill_q};

	tps_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (is_sample),
		.waddr (wpos_q),
		.wdata (sample),
		.re    (rd_en),
		.raddr (rd_idx_q[PW-1:0]),
		.rdata (rd_data)
	);

	// Configuration, flags, tick counter and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= tps_pkg::TIMEOUT_RESET;
			threshold_q <= tps_pkg::THRESHOLD_RESET;
			tick_q      <= '0;
			loss_q      <= 1'b1;
			overload_q  <= 1'b0;
			wpos_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					tps_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[TW-1:0];
					tps_pkg::REG_THRESHOLD: threshold_q <= cfg_data[SW-1:0];
					default: begin
					end
				endcase
			end
			if (ctl.accept) begin
				case (cmd)
					tps_pkg::CMD_EDGE: begin
						tick_q <= '0;
						loss_q <= 1'b0;
					end
					tps_pkg::CMD_TICK: begin
						if (tick_next >= {1'b0, timeout_q}) begin
							loss_q <= 1'b1;
							tick_q <= '0;
						end else begin
							tick_q <= tick_next[TW-1:0];
						end
					end
					tps_pkg::CMD_SAMPLE: begin
						if (sample > threshold_q) begin
							overload_q <= 1'b1;
						end
						if (wpos_q == PW'(WINDOW_DEPTH - 1)) begin
							wpos_q <= '0;
						end else begin
							wpos_q <= wpos_q + PW'(1);
						end
						if (fill_q != CW'(WINDOW_DEPTH)) begin
							fill_q <= fill_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_sample) begin
			last_q <= sample;
		end
	end

	// Window scan and divider control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (ctl.scan_clear) begin
				rd_idx_q  <= '0;
				rd_pend_q <= 1'b0;
			end else if (ctl.scan_step) begin
				rd_pend_q <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
			if (ctl.div_load) begin
				div_cnt_q <= DCW'(SW);
			end else if (ctl.div_step) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
		end
	end

	// Sum and maximum accumulate one entry per cycle; the divider then
	// produces one quotient bit per cycle. The quotient never exceeds the
	// sample range, so the upper sum bits seed the partial remainder.
	always_ff @(posedge clk) begin
		if (ctl.scan_clear) begin
			acc_sum_q <= '0;
			acc_max_q <= '0;
		end else if (ctl.scan_step && rd_pend_q) begin
			acc_sum_q <= acc_sum_q + SUM_W'(rd_data);
			if (rd_data > acc_max_q) begin
				acc_max_q <= rd_data;
			end
		end
		if (ctl.div_load) begin
			rem_q <= acc_sum_q[SUM_W-1:SW];
			quo_q <= acc_sum_q[SW-1:0];
		end else if (ctl.div_step) begin
			if (trial_ge) begin
				rem_q <= CW'(trial - {1'b0, fill_q});
			end else begin
				rem_q <= trial[CW-1:0];
			end
			quo_q <= {quo_q[SW-2:0], trial_ge};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_loss_q  <= loss_q;
			out_ovl_q   <= overload_q;
			out_stats_q <= fill_q != '0;
			out_last_q  <= (fill_q != '0) ? last_q : '0;
			out_avg_q   <= (fill_q != '0) ? quo_q : '0;
			out_max_q   <= (fill_q != '0) ? acc_max_q : '0;
		end
	end

	assign sts.scan_done = (rd_idx_q == fill_q) && !rd_pend_q;
	assign sts.div_done  = div_cnt_q == '0;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign brake_out   = out_loss_q | out_ovl_q;
	assign signal_lost = out_loss_q;
	assign overload    = out_ovl_q;
	assign stats_valid = out_stats_q;
	assign last_sample = out_last_q;
	assign average     = out_avg_q;
	assign maximum     = out_max_q;

	`TPS_ASSERT(a_fill_bound, clk, arst_n, fill_q <= CW'(WINDOW_DEPTH), "fill count overran")
	`TPS_ASSERT_IMP(a_overload_sticky, clk, arst_n, overload_q ##1 1'b1, overload_q)
	`TPS_ASSERT_IMP(a_rem_below_count, clk, arst_n, ctl.div_step, rem_q < fill_q)

endmodule

FILE: rtl/core/track_power_brake_supervisor.sv
// ---------------------------------------------------------------------------
// track_power_brake_supervisor
// Brake supervisor for a track power bridge: signal loss timeout, latched
// overcurrent and statistics over a ring of recent current samples.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   ----------------------------------------
//   in        in_valid / in_stall    cmd, sample
//   out       out_valid / out_stall  brake_out, signal_lost, overload,
//                                    stats_valid, last_sample, average, maximum
//   cfg       cfg_write              cfg_index, cfg_data
//
// Edges, ticks and unused codes pass through the accept step and the step that
// loads the result register.
// A sample is written to the ring, then its N stored samples are scanned and
// averaged: the ring RAM is read one entry per cycle (registered read port)
// and a restoring divider forms the average one quotient bit per cycle.
// Reset sets the no-signal flag (brake on with the next result) and empties the
// ring; no clearing pass is needed since only written entries are ever read.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and is held in its final step until that register is free.
//
module track_power_brake_supervisor #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_write,
	input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
	// Event items.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tps_pkg::CMD_W-1:0]      cmd,
	input  logic [tps_pkg::SAMPLE_W-1:0]   sample,
	// Result items.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           brake_out,
	output logic                           signal_lost,
	output logic                           overload,
	output logic                           stats_valid,
	output logic [tps_pkg::SAMPLE_W-1:0]   last_sample,
	output logic [tps_pkg::SAMPLE_W-1:0]   average,
	output logic [tps_pkg::SAMPLE_W-1:0]   maximum
);

	// Commands and status between the sequencer and the datapath.
	tps_pkg::dp_cmd_t ctl;
	tps_pkg::dp_sts_t sts;

	// The sequencer decides when an item is taken, when the ring is
	// scanned, when the divider runs and when the result is loaded.
	tps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// The datapath holds every register of the supervisor but the sequencer state,
	// including the configuration, the ring RAM and the result register.
	tps_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sample      (sample),
		.ctl         (ctl),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.brake_out   (brake_out),
		.signal_lost (signal_lost),
		.overload    (overload),
		.stats_valid (stats_valid),
		.last_sample (last_sample),
		.average     (average),
		.maximum     (maximum)
	);

endmodule
